>>> rtl/dpt_pkg.sv
`default_nettype none

package dpt_pkg;

  localparam int unsigned SCORE_W     = 6;
  localparam int unsigned CLASS_W     = 2;
  localparam int unsigned PORT_CW     = 16;
  localparam int unsigned MATCH_W     = 5;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned REP_W       = 7;
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 48;

  localparam logic [MATCH_W-1:0] MATCH_SAT = 5'd31;

  localparam logic [SCORE_W-1:0] INC_RESET  = 6'd3;
  localparam logic [SCORE_W-1:0] DEC_RESET  = 6'd1;
  localparam logic [SCORE_W-1:0] CEIL_RESET = 6'd20;
  localparam logic [SCORE_W-1:0] THR_RESET  = 6'd10;

  localparam logic REQ_DETECT  = 1'b0;
  localparam logic REQ_TICK    = 1'b1;
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    REG_SCORE_INC  = 2'd0,
    REG_SCORE_DEC  = 2'd1,
    REG_SCORE_CEIL = 2'd2,
    REG_REPORT_THR = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSCAN,
    ST_DDRAIN,
    ST_DFIN,
    ST_ACK,
    ST_TRD,
    ST_TEV,
    ST_TEND
  } state_e;

  typedef struct packed {
    logic load;
    logic dscan_step;
    logic dfinish;
    logic emit_ack;
    logic trd;
    logic tev_commit;
    logic tend;
  } cmd_t;

  typedef struct packed {
    logic req_tick;
    logic in_range;
    logic scan_last;
    logic pipe_empty;
    logic tick_last;
    logic out_free;
    logic tev_stall;
  } sts_t;

  typedef struct packed {
    logic               last;
    logic               ev;
    logic               dropped;
    logic               added;
    logic [MATCH_W-1:0] matched;
    logic [SCORE_W-1:0] score;
    logic [PORT_CW-1:0] y;
    logic [PORT_CW-1:0] x;
    logic [CLASS_W-1:0] cls;
    logic               kind;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/dpt_ctrl.sv
`default_nettype none

module dpt_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              s_valid_i,
  output logic             s_ready_o,
  input  dpt_pkg::sts_t    sts_i,
  output dpt_pkg::cmd_t    cmd_o
);

  dpt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dpt_pkg::ST_IDLE: begin
        if (s_valid_i) begin
          if (sts_i.req_tick) begin
            state_d = dpt_pkg::ST_TRD;
          end else if (sts_i.in_range) begin
            state_d = dpt_pkg::ST_DSCAN;
          end else begin
            state_d = dpt_pkg::ST_ACK;
          end
        end
      end
      dpt_pkg::ST_DSCAN: begin
        if (sts_i.scan_last) state_d = dpt_pkg::ST_DDRAIN;
      end
      dpt_pkg::ST_DDRAIN: begin
        if (sts_i.pipe_empty) state_d = dpt_pkg::ST_DFIN;
      end
      dpt_pkg::ST_DFIN: begin
        state_d = dpt_pkg::ST_ACK;
      end
      dpt_pkg::ST_ACK: begin
        if (sts_i.out_free) state_d = dpt_pkg::ST_IDLE;
      end
      dpt_pkg::ST_TRD: begin
        state_d = dpt_pkg::ST_TEV;
      end
      dpt_pkg::ST_TEV: begin
        if (!sts_i.tev_stall) begin
          state_d = sts_i.tick_last ? dpt_pkg::ST_TEND : dpt_pkg::ST_TRD;
        end
      end
      dpt_pkg::ST_TEND: begin
        if (sts_i.out_free) state_d = dpt_pkg::ST_IDLE;
      end
      default: state_d = dpt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    case (state_q)
      dpt_pkg::ST_IDLE: begin
        s_ready_o    = 1'b1;
        cmd_o.load   = s_valid_i;
      end
      dpt_pkg::ST_DSCAN:  cmd_o.dscan_step = 1'b1;
      dpt_pkg::ST_DDRAIN: ;
      dpt_pkg::ST_DFIN:   cmd_o.dfinish    = 1'b1;
      dpt_pkg::ST_ACK:    cmd_o.emit_ack   = sts_i.out_free;
      dpt_pkg::ST_TRD:    cmd_o.trd        = 1'b1;
      dpt_pkg::ST_TEV:    cmd_o.tev_commit = !sts_i.tev_stall;
      dpt_pkg::ST_TEND:   cmd_o.tend       = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/dpt_datapath.sv
`default_nettype none

module dpt_datapath #(
  parameter int unsigned NUM_CLASSES       = 4,
  parameter int unsigned ENTRIES_PER_CLASS = 16,
  parameter int unsigned COORD_WIDTH       = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_valid_i,
  input  wire  [1:0]                          cfg_index_i,
  input  wire  [dpt_pkg::SCORE_W-1:0]         cfg_data_i,
  input  wire                                 s_tuser_i,
  input  wire  [dpt_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  wire                                 m_ready_i,
  input  dpt_pkg::cmd_t                       cmd_i,
  output dpt_pkg::sts_t                       sts_o,
  output logic                                m_valid_o,
  output dpt_pkg::out_item_t                  m_item_o
);

  localparam int unsigned TOTAL  = NUM_CLASSES * ENTRIES_PER_CLASS;
  localparam int unsigned SLOT_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned IDX_W  = (ENTRIES_PER_CLASS > 1) ? $clog2(ENTRIES_PER_CLASS) : 1;
  localparam int unsigned CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned CW     = (COORD_WIDTH < dpt_pkg::PORT_CW) ? COORD_WIDTH
                                                                    : dpt_pkg::PORT_CW;
  localparam int unsigned SQ_W   = 2 * CW;
  localparam int unsigned MEM_W  = 2 * CW + dpt_pkg::SCORE_W;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES_PER_CLASS - 1);
  localparam logic [CLS_W-1:0] CLS_LAST = CLS_W'(NUM_CLASSES - 1);
  localparam logic [dpt_pkg::REP_W-1:0] REP_CAP = dpt_pkg::REP_W'(dpt_pkg::MAX_RESULTS);

  // incoming transaction fields
  logic [dpt_pkg::CLASS_W-1:0] s_cls;
  logic [CW-1:0]               s_x, s_y, s_r;
  logic [SQ_W-1:0]             r_sq;
  logic [SLOT_W-1:0]           base;

  assign s_cls = s_tdata_i[1:0];
  assign s_x   = s_tdata_i[2 +: CW];
  assign s_y   = s_tdata_i[18 +: CW];
  assign s_r   = s_tdata_i[34 +: CW];
  assign r_sq  = SQ_W'(s_r) * SQ_W'(s_r);
  assign base  = SLOT_W'(32'(s_cls) * ENTRIES_PER_CLASS);

  // configuration registers
  logic [dpt_pkg::SCORE_W-1:0] inc_q, dec_q, ceil_q, thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q  <= dpt_pkg::INC_RESET;
      dec_q  <= dpt_pkg::DEC_RESET;
      ceil_q <= dpt_pkg::CEIL_RESET;
      thr_q  <= dpt_pkg::THR_RESET;
    end else if (cfg_valid_i) begin
      case (dpt_pkg::cfg_reg_e'(cfg_index_i))
        dpt_pkg::REG_SCORE_INC:  inc_q  <= cfg_data_i;
        dpt_pkg::REG_SCORE_DEC:  dec_q  <= cfg_data_i;
        dpt_pkg::REG_SCORE_CEIL: ceil_q <= cfg_data_i;
        dpt_pkg::REG_REPORT_THR: thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request latch
  logic [dpt_pkg::CLASS_W-1:0] cls_q;
  logic [CW-1:0]               px_q, py_q;
  logic [SQ_W-1:0]             r2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cls_q <= s_cls;
      px_q  <= s_x;
      py_q  <= s_y;
      r2_q  <= r_sq;
    end
  end

  // scan counters
  logic [SLOT_W-1:0] addr_q;
  logic [IDX_W-1:0]  cnt_q;
  logic [CLS_W-1:0]  tcls_q;
  logic              scan_last;

  assign scan_last = (cnt_q == IDX_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      cnt_q  <= '0;
      tcls_q <= '0;
    end else if (cmd_i.load) begin
      addr_q <= (s_tuser_i == dpt_pkg::REQ_TICK) ? '0 : base;
      cnt_q  <= '0;
      tcls_q <= '0;
    end else if (cmd_i.dscan_step || cmd_i.tev_commit) begin
      addr_q <= addr_q + 1'b1;
      if (scan_last) begin
        cnt_q  <= '0;
        tcls_q <= tcls_q + 1'b1;
      end else begin
        cnt_q  <= cnt_q + 1'b1;
      end
    end
  end

  // point table: {score, y, x}
  logic [MEM_W-1:0]  mem [TOTAL];
  logic [MEM_W-1:0]  rdata_q;
  logic              rd_en;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [MEM_W-1:0]  wr_data;
  logic [TOTAL-1:0]  live_q;

  assign rd_en = cmd_i.dscan_step || cmd_i.trd;

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  logic [CW-1:0]               rd_x, rd_y;
  logic [dpt_pkg::SCORE_W-1:0] rd_sc;

  assign rd_x  = rdata_q[CW-1:0];
  assign rd_y  = rdata_q[2*CW-1:CW];
  assign rd_sc = rdata_q[MEM_W-1:2*CW];

  // detection pipeline: read, square, compare/update
  logic              v1_q, v2_q;
  logic [SLOT_W-1:0] a1_q, a2_q;
  logic [MEM_W-1:0]  w2_q;
  logic              l2_q;
  logic [SQ_W-1:0]   dx2_q, dy2_q;
  logic              live1;
  logic [CW-1:0]     dx, dy;
  logic              new_free;
  logic              free_found_q;

  assign live1    = live_q[a1_q];
  assign dx       = (rd_x > px_q) ? (rd_x - px_q) : (px_q - rd_x);
  assign dy       = (rd_y > py_q) ? (rd_y - py_q) : (py_q - rd_y);
  assign new_free = v1_q && !live1 && !free_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.dscan_step;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dscan_step) a1_q <= addr_q;
    if (v1_q) begin
      a2_q  <= a1_q;
      w2_q  <= rdata_q;
      l2_q  <= live1;
      dx2_q <= SQ_W'(dx) * SQ_W'(dx);
      dy2_q <= SQ_W'(dy) * SQ_W'(dy);
    end
  end

  logic [SQ_W:0]               dsq_sum;
  logic                        hit;
  logic [dpt_pkg::SCORE_W:0]   sc_sum;
  logic [dpt_pkg::SCORE_W-1:0] new_sc;

  assign dsq_sum = {1'b0, dx2_q} + {1'b0, dy2_q};
  assign hit     = v2_q && l2_q && (dsq_sum < {1'b0, r2_q});
  assign sc_sum  = {1'b0, w2_q[MEM_W-1:2*CW]} + {1'b0, inc_q};
  assign new_sc  = (sc_sum > {1'b0, ceil_q}) ? ceil_q : sc_sum[dpt_pkg::SCORE_W-1:0];

  // detection outcome
  logic [dpt_pkg::MATCH_W-1:0] matched_q;
  logic                        added_q, dropped_q;
  logic [SLOT_W-1:0]           free_slot_q;
  logic                        do_add;

  assign do_add = cmd_i.dfinish && (matched_q == '0) && free_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q    <= '0;
      added_q      <= 1'b0;
      dropped_q    <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      matched_q    <= '0;
      added_q      <= 1'b0;
      dropped_q    <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      if (hit && (matched_q != dpt_pkg::MATCH_SAT)) matched_q <= matched_q + 1'b1;
      if (new_free) free_found_q <= 1'b1;
      if (cmd_i.dfinish && (matched_q == '0)) begin
        if (free_found_q) added_q <= 1'b1;
        else dropped_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_free) free_slot_q <= a1_q;
  end

  // tick: decay of the slot just read
  logic                        t_live, t_free, t_rep;
  logic [dpt_pkg::SCORE_W-1:0] t_sc;
  logic [dpt_pkg::REP_W-1:0]   nrep_q;
  logic                        pend_valid_q;
  logic                        out_free;

  assign t_live = live_q[addr_q];
  assign t_free = t_live && (rd_sc < dec_q);
  assign t_sc   = rd_sc - dec_q;
  assign t_rep  = t_live && !t_free && (t_sc > thr_q) && (nrep_q < REP_CAP);

  // write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = a2_q;
    wr_data = w2_q;
    if (hit) begin
      wr_en   = 1'b1;
      wr_data = {new_sc, w2_q[2*CW-1:0]};
    end else if (cmd_i.dfinish) begin
      wr_en   = do_add;
      wr_addr = free_slot_q;
      wr_data = {inc_q, py_q, px_q};
    end else if (cmd_i.tev_commit) begin
      wr_en   = t_live && !t_free;
      wr_addr = addr_q;
      wr_data = {t_sc, rdata_q[2*CW-1:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
    end else if (do_add) begin
      live_q[free_slot_q] <= 1'b1;
    end else if (cmd_i.tev_commit && t_free) begin
      live_q[addr_q] <= 1'b0;
    end
  end

  // one report held back so the final one can carry last
  logic [dpt_pkg::CLASS_W-1:0] pend_cls_q;
  logic [CW-1:0]               pend_x_q, pend_y_q;
  logic [dpt_pkg::SCORE_W-1:0] pend_sc_q;
  logic                        take_rep;

  assign take_rep = cmd_i.tev_commit && t_rep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      nrep_q       <= '0;
    end else if (cmd_i.load) begin
      pend_valid_q <= 1'b0;
      nrep_q       <= '0;
    end else if (take_rep) begin
      pend_valid_q <= 1'b1;
      nrep_q       <= nrep_q + 1'b1;
    end else if (cmd_i.tend) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_rep) begin
      pend_cls_q <= dpt_pkg::CLASS_W'(tcls_q);
      pend_x_q   <= rd_x;
      pend_y_q   <= rd_y;
      pend_sc_q  <= t_sc;
    end
  end

  // output register
  logic               out_valid_q;
  dpt_pkg::out_item_t out_q, item_d;
  logic               push;

  assign out_free = !out_valid_q || m_ready_i;
  assign push     = cmd_i.emit_ack || cmd_i.tend || (take_rep && pend_valid_q);

  always_comb begin
    item_d = '0;
    if (cmd_i.emit_ack) begin
      item_d.kind    = dpt_pkg::KIND_ACK;
      item_d.cls     = cls_q;
      item_d.matched = matched_q;
      item_d.added   = added_q;
      item_d.dropped = dropped_q;
      item_d.last    = 1'b1;
    end else if (cmd_i.tend && !pend_valid_q) begin
      item_d.kind = dpt_pkg::KIND_REPORT;
      item_d.last = 1'b1;
    end else begin
      item_d.kind  = dpt_pkg::KIND_REPORT;
      item_d.cls   = pend_cls_q;
      item_d.x     = dpt_pkg::PORT_CW'(pend_x_q);
      item_d.y     = dpt_pkg::PORT_CW'(pend_y_q);
      item_d.score = pend_sc_q;
      item_d.ev    = 1'b1;
      item_d.last  = cmd_i.tend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) out_q <= item_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_item_o  = out_q;

  always_comb begin
    sts_o            = '0;
    sts_o.req_tick   = (s_tuser_i == dpt_pkg::REQ_TICK);
    sts_o.in_range   = (32'(s_cls) < NUM_CLASSES);
    sts_o.scan_last  = scan_last;
    sts_o.pipe_empty = !v1_q && !v2_q;
    sts_o.tick_last  = scan_last && (tcls_q == CLS_LAST);
    sts_o.out_free   = out_free;
    sts_o.tev_stall  = t_rep && pend_valid_q && !out_free;
  end

`ifndef NO_ASSERTIONS
  a_add_to_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_add |-> !live_q[free_slot_q])
    else $error("new entry placed on a live slot");

  a_ack_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_ack |-> !(added_q && dropped_q) && !(added_q && (matched_q != '0)))
    else $error("inconsistent detection outcome");

  a_pending_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tend |-> (pend_valid_q == (nrep_q != '0)))
    else $error("pending report out of step with report count");

  a_load_pipe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (!v1_q && !v2_q))
    else $error("new request while scan pipeline busy");

  a_write_port_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |-> (!cmd_i.dfinish && !cmd_i.tev_commit))
    else $error("write port contention");
`endif

endmodule

`default_nettype wire

>>> rtl/detection_persistence_tracker_unit.sv
// Detection persistence tracker.
// Input stream (s_axis_*): tuser = request type (detection or frame tick);
// tdata = class, x, y, radius. Output stream (m_axis_*): tuser = item kind,
// tlast marks the final item of a request. Config writes (cfg_*) set the
// score increment, decrement, ceiling and report threshold; do them only
// while the block has no request in flight.
// A detection scans its class's table through a three-stage read/square/
// update pipeline, one entry a cycle, and ends in a single acknowledgement;
// the next request can be taken in the same cycle that it appears. A
// frame tick visits every slot in two steps (table read, then decay
// write-back), emitting report items as it goes.
// One request is in flight at a time; the output register lets the next
// request be accepted while the last result still waits.
// Reset empties all tables and loads the register defaults; no clearing
// pass is needed. A stalled receiver holds the output register and pauses
// the tick scan or the acknowledgement until it drains.
`default_nettype none

module detection_persistence_tracker_unit #(
  parameter int unsigned NUM_CLASSES       = 4,
  parameter int unsigned ENTRIES_PER_CLASS = 16,
  parameter int unsigned COORD_WIDTH       = 16
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // class_index[1:0], x_pos[17:2], y_pos[33:18], radius[49:34], zero pad
  input  wire  [dpt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // req_type[0]
  input  wire                                 s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // out_class[1:0], out_x[17:2], out_y[33:18], out_score[39:34],
  // matched_count[44:40], added[45], dropped_full[46], entry_valid[47]
  output logic [dpt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // kind[0]
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast,
  input  wire                                 cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire  [1:0]                          cfg_index_i,
  input  wire  [dpt_pkg::SCORE_W-1:0]         cfg_data_i
);

  dpt_pkg::cmd_t      cmd;
  dpt_pkg::sts_t      sts;
  dpt_pkg::out_item_t item;

  dpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  dpt_datapath #(
    .NUM_CLASSES       (NUM_CLASSES),
    .ENTRIES_PER_CLASS (ENTRIES_PER_CLASS),
    .COORD_WIDTH       (COORD_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tuser_i   (s_axis_tuser),
    .s_tdata_i   (s_axis_tdata),
    .m_ready_i   (m_axis_tready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_valid_o   (m_axis_tvalid),
    .m_item_o    (item)
  );

  assign cfg_ready_o  = 1'b1;
  assign m_axis_tuser = item.kind;
  assign m_axis_tlast = item.last;
  assign m_axis_tdata = {item.ev, item.dropped, item.added, item.matched,
                         item.score, item.y, item.x, item.cls};

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps

// Tracks what the block should hold and queues the result items that each
// accepted request should produce.
class track_scoreboard;
  localparam int CLASSES   = 4;
  localparam int PER_CLASS = 16;
  localparam int SLOTS     = CLASSES * PER_CLASS;

  logic [15:0] pos_x [SLOTS];
  logic [15:0] pos_y [SLOTS];
  logic [5:0]  pt_score [SLOTS];
  bit          pt_live [SLOTS];

  logic [5:0] inc_r;
  logic [5:0] dec_r;
  logic [5:0] ceil_r;
  logic [5:0] thr_r;

  dpt_pkg::out_item_t expected_q[$];
  int unsigned errors;
  int unsigned seen;

  function new();
    foreach (pt_live[i]) pt_live[i] = 1'b0;
    inc_r  = dpt_pkg::INC_RESET;
    dec_r  = dpt_pkg::DEC_RESET;
    ceil_r = dpt_pkg::CEIL_RESET;
    thr_r  = dpt_pkg::THR_RESET;
    errors = 0;
    seen   = 0;
  endfunction

  function void set_reg(dpt_pkg::cfg_reg_e idx, logic [5:0] val);
    case (idx)
      dpt_pkg::REG_SCORE_INC:  inc_r  = val;
      dpt_pkg::REG_SCORE_DEC:  dec_r  = val;
      dpt_pkg::REG_SCORE_CEIL: ceil_r = val;
      dpt_pkg::REG_REPORT_THR: thr_r  = val;
      default: ;
    endcase
  endfunction

  function void queue_result(dpt_pkg::out_item_t it);
    expected_q = {expected_q, it};
  endfunction

  // Update the tables for one accepted request and queue its result items.
  function void note_request(logic req, logic [1:0] cls, logic [15:0] px,
                             logic [15:0] py, logic [15:0] rad);
    dpt_pkg::out_item_t item;
    longint unsigned r2, dx, dy;
    int i, s, free_slot, hits, total;
    int unsigned sum;
    item = '0;
    item.last = 1'b1;
    if (req == dpt_pkg::REQ_DETECT) begin
      item.kind = dpt_pkg::KIND_ACK;
      item.cls  = cls;
      r2 = rad;
      r2 = r2 * r2;
      free_slot = -1;
      hits = 0;
      for (i = 0; i < PER_CLASS; i++) begin
        s = cls * PER_CLASS + i;
        if (!pt_live[s]) begin
          if (free_slot < 0) free_slot = s;
        end else begin
          dx = (pos_x[s] > px) ? pos_x[s] - px : px - pos_x[s];
          dy = (pos_y[s] > py) ? pos_y[s] - py : py - pos_y[s];
          if (dx * dx + dy * dy < r2) begin
            sum = pt_score[s] + inc_r;
            if (sum > ceil_r) sum = ceil_r;
            pt_score[s] = sum[5:0];
            if (hits < 31) hits++;
          end
        end
      end
      item.matched = hits[4:0];
      if (hits == 0) begin
        if (free_slot >= 0) begin
          pos_x[free_slot]    = px;
          pos_y[free_slot]    = py;
          pt_score[free_slot] = inc_r;   // new entry is not clamped
          pt_live[free_slot]  = 1'b1;
          item.added = 1'b1;
        end else begin
          item.dropped = 1'b1;
        end
      end
      queue_result(item);
    end else begin
      for (s = 0; s < SLOTS; s++) begin
        if (pt_live[s]) begin
          if (pt_score[s] < dec_r) pt_live[s] = 1'b0;
          else pt_score[s] = pt_score[s] - dec_r;
        end
      end
      total = 0;
      for (s = 0; s < SLOTS; s++)
        if (pt_live[s] && pt_score[s] > thr_r) total++;
      if (total > dpt_pkg::MAX_RESULTS) total = dpt_pkg::MAX_RESULTS;
      item.kind = dpt_pkg::KIND_REPORT;
      if (total == 0) begin
        queue_result(item);
      end else begin
        hits = 0;
        for (s = 0; s < SLOTS; s++) begin
          if (pt_live[s] && pt_score[s] > thr_r && hits < total) begin
            item.cls   = 2'(s / PER_CLASS);
            item.x     = pos_x[s];
            item.y     = pos_y[s];
            item.score = pt_score[s];
            item.ev    = 1'b1;
            item.last  = (hits == total - 1);
            queue_result(item);
            hits++;
          end
        end
      end
    end
  endfunction

  task report_mismatch(string msg);
    if (errors < 100) $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task cmp_field(string name, logic [31:0] got_v, logic [31:0] want_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                seen, name, got_v, want_v));
  endtask

  task check_result(dpt_pkg::out_item_t got);
    dpt_pkg::out_item_t want;
    seen++;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with nothing pending", seen));
      return;
    end
    want = expected_q.pop_front();
    cmp_field("kind", got.kind, want.kind);
    cmp_field("class", got.cls, want.cls);
    cmp_field("x", got.x, want.x);
    cmp_field("y", got.y, want.y);
    cmp_field("score", got.score, want.score);
    cmp_field("matched_count", got.matched, want.matched);
    cmp_field("added", got.added, want.added);
    cmp_field("dropped_full", got.dropped, want.dropped);
    cmp_field("entry_valid", got.ev, want.ev);
    cmp_field("last", got.last, want.last);
  endtask
endclass

module tb_top;

  // a tick reads and writes back every slot in turn, plus some margin
  localparam int SETTLE_CYCLES = 2 * 64 + 16;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [dpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [dpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            m_axis_tlast;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [1:0]                      cfg_index_i;
  logic [dpt_pkg::SCORE_W-1:0]     cfg_data_i;

  int src_idle;
  int sink_idle;
  track_scoreboard sb;

  detection_persistence_tracker_unit uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver: random backpressure, and check every accepted result
  always @(posedge clk_i) begin
    dpt_pkg::out_item_t got;
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind    = m_axis_tuser;
      got.last    = m_axis_tlast;
      got.cls     = m_axis_tdata[1:0];
      got.x       = m_axis_tdata[17:2];
      got.y       = m_axis_tdata[33:18];
      got.score   = m_axis_tdata[39:34];
      got.matched = m_axis_tdata[44:40];
      got.added   = m_axis_tdata[45];
      got.dropped = m_axis_tdata[46];
      got.ev      = m_axis_tdata[47];
      sb.check_result(got);
    end
  end

  // tvalid stays high from one request to the next unless a gap is drawn
  task automatic send_req(input logic req, input logic [1:0] cls,
                          input logic [15:0] px, input logic [15:0] py,
                          input logic [15:0] rad);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {6'd0, rad, py, px, cls};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req, cls, px, py, rad);
  endtask

  task automatic send_random();
    int pick, i, n_live, choice, slot;
    logic [1:0]  cls;
    logic [15:0] px, py, rad;
    pick = $urandom_range(0, 99);
    cls  = 2'($urandom_range(0, 3));
    px   = 16'($urandom);
    py   = 16'($urandom);
    rad  = 16'($urandom);
    n_live = 0;
    for (i = 0; i < 16; i++) if (sb.pt_live[cls * 16 + i]) n_live++;
    if (pick < 15) begin
      send_req(dpt_pkg::REQ_TICK, cls, px, py, rad);
    end else if (pick < 65 && n_live > 0) begin
      // land near a tracked point so scores build up
      choice = $urandom_range(0, n_live - 1);
      slot = -1;
      for (i = 0; i < 16; i++) begin
        if (sb.pt_live[cls * 16 + i]) begin
          if (choice == 0 && slot < 0) slot = cls * 16 + i;
          choice--;
        end
      end
      px  = sb.pos_x[slot] + 16'($urandom_range(0, 127)) - 16'd64;
      py  = sb.pos_y[slot] + 16'($urandom_range(0, 127)) - 16'd64;
      rad = 16'($urandom_range(64, 600));
      send_req(dpt_pkg::REQ_DETECT, cls, px, py, rad);
    end else if (pick < 85) begin
      px  = 16'($urandom_range(0, 7) * 16'h2000 + $urandom_range(0, 255));
      py  = 16'($urandom_range(0, 7) * 16'h2000 + $urandom_range(0, 255));
      rad = 16'($urandom_range(0, 512));
      send_req(dpt_pkg::REQ_DETECT, cls, px, py, rad);
    end else begin
      send_req(dpt_pkg::REQ_DETECT, cls, px, py, rad);
    end
  endtask

  task automatic load_regs(input logic [5:0] inc, input logic [5:0] dec,
                           input logic [5:0] ceil, input logic [5:0] thr);
    dpt_pkg::cfg_reg_e regs [4];
    logic [5:0]        vals [4];
    int i;
    regs[0] = dpt_pkg::REG_SCORE_INC;
    regs[1] = dpt_pkg::REG_SCORE_DEC;
    regs[2] = dpt_pkg::REG_SCORE_CEIL;
    regs[3] = dpt_pkg::REG_REPORT_THR;
    vals[0] = inc;
    vals[1] = dec;
    vals[2] = ceil;
    vals[3] = thr;
    cfg_valid_i <= 1'b1;
    for (i = 0; i < 4; i++) begin
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // stop sending, wait out every pending result and the tail of the scan
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int seg, i;
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = dpt_pkg::REG_SCORE_INC;
    cfg_data_i    = '0;
    src_idle      = 35;
    sink_idle     = 54;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, register defaults
    // radius zero never matches, so a duplicate point becomes a second entry
    send_req(dpt_pkg::REQ_DETECT, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    send_req(dpt_pkg::REQ_DETECT, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    send_req(dpt_pkg::REQ_DETECT, 2'd0, 16'h0000, 16'h0000, 16'h0001);
    // coordinate extremes; opposite corners stay apart at full radius
    send_req(dpt_pkg::REQ_DETECT, 2'd3, 16'hffff, 16'hffff, 16'hffff);
    send_req(dpt_pkg::REQ_DETECT, 2'd3, 16'h0000, 16'h0000, 16'hffff);
    send_req(dpt_pkg::REQ_DETECT, 2'd3, 16'h8000, 16'h8000, 16'hffff);
    send_req(dpt_pkg::REQ_DETECT, 2'd2, 16'h1234, 16'habcd, 16'h0010);
    send_req(dpt_pkg::REQ_TICK, 2'd0, 16'h0000, 16'h0000, 16'h0000);
    // fill class 1, then one more point that has no room
    for (i = 0; i < 17; i++)
      send_req(dpt_pkg::REQ_DETECT, 2'd1, 16'($urandom), 16'($urandom), 16'h0000);
    send_req(dpt_pkg::REQ_TICK, 2'd3, 16'hffff, 16'hffff, 16'hffff);

    for (seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        src_idle  = 54;
        sink_idle = 35;
      end
      if (seg == 4) begin
        src_idle  = 0;
        sink_idle = 0;
      end
      settle();
      case (seg)
        0: load_regs(6'd5, 6'd2, 6'd30, 6'd8);
        1: load_regs(6'd1, 6'd1, 6'd1, 6'd0);
        2: load_regs(6'd63, 6'd63, 6'd63, 6'd63);
        3: load_regs(6'd40, 6'd7, 6'd12, 6'd5);   // new entries start above ceiling
        4: load_regs(6'd9, 6'd3, 6'd50, 6'd20);
        default: load_regs(6'd3, 6'd1, 6'd20, 6'd10);
      endcase
      repeat (23) send_random();
    end

    settle();
    if (sb.errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end
endmodule
